>>> rtl/tcc_pkg.sv
// Shared constants, types and helpers for the tetrahedron circumcenter pipeline.
package tcc_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int CENTER_WIDTH_DEF = 24;

	// Cycles from the start transfer to the done strobe.
	function automatic int tcc_latency(input int center_width);
		return 8 + center_width + 1;
	endfunction

	typedef struct packed {
		logic       valid;
		logic       degen;
		logic [2:0] qneg;
		logic [2:0] ovf;
	} tcc_ctl_t;

endpackage

>>> rtl/tetrahedron_circumcenter_top.sv
// Top level of the pipelined tetrahedron circumcenter unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | start, busy          | p0_x .. p3_z, COORD_WIDTH bits signed
//  result   | done (one-cycle)     | center_x/y/z CENTER_WIDTH bits, degenerate, clipped
//
// One tetrahedron can enter every cycle; busy is always low.
// The result passes through seven arithmetic stages, one divider stage per
// quotient bit and the output register.
// Reset clears only the valid and control flags; no result is strobed while they drain.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module tetrahedron_circumcenter_top #(
	parameter int COORD_WIDTH  = tcc_pkg::COORD_WIDTH_DEF,
	parameter int CENTER_WIDTH = tcc_pkg::CENTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [COORD_WIDTH-1:0]  p0_x,
	input  logic signed [COORD_WIDTH-1:0]  p0_y,
	input  logic signed [COORD_WIDTH-1:0]  p0_z,
	input  logic signed [COORD_WIDTH-1:0]  p1_x,
	input  logic signed [COORD_WIDTH-1:0]  p1_y,
	input  logic signed [COORD_WIDTH-1:0]  p1_z,
	input  logic signed [COORD_WIDTH-1:0]  p2_x,
	input  logic signed [COORD_WIDTH-1:0]  p2_y,
	input  logic signed [COORD_WIDTH-1:0]  p2_z,
	input  logic signed [COORD_WIDTH-1:0]  p3_x,
	input  logic signed [COORD_WIDTH-1:0]  p3_y,
	input  logic signed [COORD_WIDTH-1:0]  p3_z,
	output logic                           done,
	output logic signed [CENTER_WIDTH-1:0] center_x,
	output logic signed [CENTER_WIDTH-1:0] center_y,
	output logic signed [CENTER_WIDTH-1:0] center_z,
	output logic                           degenerate,
	output logic                           clipped
);
	import tcc_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int EW   = CW + 1;
	localparam int PW   = 2 * EW;
	localparam int XW   = PW + 1;
	localparam int DW   = PW + 2;
	localparam int LH   = DW / 2;
	localparam int HW   = DW - LH;
	localparam int DETW = EW + XW + 3;
	localparam int NW   = XW + DW + 2;
	localparam int QB   = CENTER_WIDTH + 1;
	localparam int RW   = DETW + 1;
	localparam int CMPW = (NW > DETW + QB) ? NW : DETW + QB;
	localparam int SW   = QB + CW + 2;

	logic signed [CW-1:0] pv [0:3][0:2];

	assign pv[0] = '{p0_x, p0_y, p0_z};
	assign pv[1] = '{p1_x, p1_y, p1_z};
	assign pv[2] = '{p2_x, p2_y, p2_z};
	assign pv[3] = '{p3_x, p3_y, p3_z};

	assign busy = 1'b0;

	// Stage valid bits up to the point where flags join them.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [EW-1:0]   e_s1  [0:2][0:2];
	logic [2:0][CW-1:0]     p0_s1, p0_s2, p0_s3, p0_s4, p0_s5, p0_s6, p0_s7;
	logic signed [EW-1:0]   b_s2  [0:2];
	logic signed [EW-1:0]   b_s3  [0:2];
	logic signed [PW-1:0]   pa_s2 [0:2][0:2];
	logic signed [PW-1:0]   pb_s2 [0:2][0:2];
	logic signed [PW-1:0]   sq_s2 [0:2][0:2];
	logic signed [XW-1:0]   x_s3  [0:2][0:2];
	logic signed [DW-1:0]   dt_s3 [0:2];
	logic signed [EW+XW-1:0]   dp_s4  [0:2];
	logic signed [XW+HW:0]     nhi_s4 [0:2][0:2];
	logic signed [XW+LH:0]     nlo_s4 [0:2][0:2];
	logic signed [DETW-1:0] det_s5;
	logic signed [NW-1:0]   num_s5 [0:2];
	tcc_ctl_t               ctl_s6, ctl_s7, ctl_dv;
	logic [DETW-1:0]        dmag_s6, dmag_s7;
	logic [NW-1:0]          nmag_s6 [0:2];
	logic [2:0][RW-1:0]     rem_s7;
	logic [2:0][QB-1:0]     numlo_s7;
	logic [2:0][QB-1:0]     q_dv;
	logic [2:0][CW-1:0]     p0_dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: edge vectors from vertex zero.
	for (genvar k = 0; k < 3; k++) begin : g_edge
		for (genvar i = 0; i < 3; i++) begin : g_ax
			always_ff @(posedge clk) begin
				e_s1[k][i] <= EW'(pv[k+1][i]) - EW'(pv[0][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		p0_s1 <= {p0_z, p0_y, p0_x};
		p0_s2 <= p0_s1;
		p0_s3 <= p0_s2;
		p0_s4 <= p0_s3;
		p0_s5 <= p0_s4;
		p0_s6 <= p0_s5;
		p0_s7 <= p0_s6;
		b_s2  <= e_s1[0];
		b_s3  <= b_s2;
	end

	// Stage 2: cross k is e[k+1] x e[k+2], weighted later by |e[k]|^2.
	for (genvar k = 0; k < 3; k++) begin : g_crs
		for (genvar i = 0; i < 3; i++) begin : g_ax
			always_ff @(posedge clk) begin
				pa_s2[k][i] <= e_s1[(k+1)%3][(i+1)%3] * e_s1[(k+2)%3][(i+2)%3];
				pb_s2[k][i] <= e_s1[(k+1)%3][(i+2)%3] * e_s1[(k+2)%3][(i+1)%3];
				sq_s2[k][i] <= e_s1[k][i] * e_s1[k][i];
			end
		end

		// Stage 3: cross products and squared lengths.
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				x_s3[k][i] <= XW'(pa_s2[k][i]) - XW'(pb_s2[k][i]);
			end
			dt_s3[k] <= DW'(sq_s2[k][0]) + DW'(sq_s2[k][1]) + DW'(sq_s2[k][2]);
		end

		// Stage 4: determinant terms and split numerator products.
		always_ff @(posedge clk) begin
			dp_s4[k] <= b_s3[k] * x_s3[0][k];
			for (int i = 0; i < 3; i++) begin
				nhi_s4[k][i] <= x_s3[k][i] * $signed({1'b0, dt_s3[k][DW-1:LH]});
				nlo_s4[k][i] <= x_s3[k][i] * $signed({1'b0, dt_s3[k][LH-1:0]});
			end
		end
	end

	// Stage 5: sums.
	always_ff @(posedge clk) begin
		det_s5 <= (DETW'(dp_s4[0]) + DETW'(dp_s4[1]) + DETW'(dp_s4[2])) <<< 1;
		for (int i = 0; i < 3; i++) begin
			num_s5[i] <= (NW'(nhi_s4[0][i]) <<< LH) + NW'(nlo_s4[0][i])
				+ (NW'(nhi_s4[1][i]) <<< LH) + NW'(nlo_s4[1][i])
				+ (NW'(nhi_s4[2][i]) <<< LH) + NW'(nlo_s4[2][i]);
		end
	end

	// Stage 6: magnitudes and signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s6.valid <= v_s5;
			ctl_s6.degen <= det_s5 == '0;
			ctl_s6.ovf   <= '0;
			for (int i = 0; i < 3; i++) begin
				ctl_s6.qneg[i] <= num_s5[i][NW-1] ^ det_s5[DETW-1];
			end
			ctl_s7.valid <= ctl_s6.valid;
			ctl_s7.degen <= ctl_s6.degen;
			ctl_s7.qneg  <= ctl_s6.qneg;
			for (int i = 0; i < 3; i++) begin
				ctl_s7.ovf[i] <= CMPW'(nmag_s6[i]) >= (CMPW'(dmag_s6) << QB);
			end
		end
	end

	always_ff @(posedge clk) begin
		dmag_s6 <= det_s5[DETW-1] ? DETW'(-det_s5) : DETW'(det_s5);
		for (int i = 0; i < 3; i++) begin
			nmag_s6[i] <= num_s5[i][NW-1] ? NW'(-num_s5[i]) : NW'(num_s5[i]);
		end
		// Stage 7: quotient bits above QB are zero unless the lane overflows.
		dmag_s7 <= dmag_s6;
		for (int i = 0; i < 3; i++) begin
			rem_s7[i]   <= RW'(CMPW'(nmag_s6[i]) >> QB);
			numlo_s7[i] <= nmag_s6[i][QB-1:0];
		end
	end

	tcc_div #(
		.QB  (QB),
		.DMW (DETW),
		.PCW (CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_i   (ctl_s7),
		.rem_i   (rem_s7),
		.numlo_i (numlo_s7),
		.det_i   (dmag_s7),
		.p0_i    (p0_s7),
		.ctl_o   (ctl_dv),
		.q_o     (q_dv),
		.p0_o    (p0_dv)
	);

	// Output stage: apply sign, add vertex zero, saturate.
	logic signed [SW-1:0]           sum   [0:2];
	logic signed [CENTER_WIDTH-1:0] sat   [0:2];
	logic [2:0]                     clip;

	always_comb begin
		logic [QB:0]          mag;
		logic signed [SW-1:0] off;
		logic [SW-CENTER_WIDTH:0] up;
		for (int i = 0; i < 3; i++) begin
			mag = ctl_dv.ovf[i] ? (QB+1)'(1) << QB : {1'b0, q_dv[i]};
			off = ctl_dv.qneg[i] ? -SW'(mag) : SW'(mag);
			if (ctl_dv.degen) begin
				off = '0;
			end
			sum[i]  = SW'($signed(p0_dv[i])) + off;
			up      = sum[i][SW-1:CENTER_WIDTH-1];
			clip[i] = !((&up) || !(|up));
			if (!clip[i]) begin
				sat[i] = sum[i][CENTER_WIDTH-1:0];
			end else if (sum[i][SW-1]) begin
				sat[i] = {1'b1, {(CENTER_WIDTH-1){1'b0}}};
			end else begin
				sat[i] = {1'b0, {(CENTER_WIDTH-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		center_x   <= sat[0];
		center_y   <= sat[1];
		center_z   <= sat[2];
		degenerate <= ctl_dv.degen;
		clipped    <= |clip;
	end

endmodule

>>> rtl/tcc_div.sv
// Three-lane restoring divider, one quotient bit per pipeline stage.
module tcc_div #(
	parameter int QB  = 25,
	parameter int DMW = 55,
	parameter int PCW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcc_pkg::tcc_ctl_t            ctl_i,
	input  logic [2:0][DMW:0]            rem_i,
	input  logic [2:0][QB-1:0]           numlo_i,
	input  logic [DMW-1:0]               det_i,
	input  logic [2:0][PCW-1:0]          p0_i,
	output tcc_pkg::tcc_ctl_t            ctl_o,
	output logic [2:0][QB-1:0]           q_o,
	output logic [2:0][PCW-1:0]          p0_o
);
	import tcc_pkg::*;

	localparam int RW = DMW + 1;

	tcc_ctl_t            ctl_s   [0:QB];
	logic [2:0][RW-1:0]  rem_s   [0:QB];
	logic [2:0][QB-1:0]  numlo_s [0:QB];
	logic [2:0][QB-1:0]  q_s     [0:QB];
	logic [DMW-1:0]      det_s   [0:QB];
	logic [2:0][PCW-1:0] p0_s    [0:QB];

	assign ctl_s[0]   = ctl_i;
	assign rem_s[0]   = rem_i;
	assign numlo_s[0] = numlo_i;
	assign q_s[0]     = '0;
	assign det_s[0]   = det_i;
	assign p0_s[0]    = p0_i;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [2:0][RW-1:0] trial;
		logic [2:0]         ge;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial[l] = {rem_s[k][l][RW-2:0], numlo_s[k][l][QB-1-k]};
				ge[l]    = trial[l] >= {1'b0, det_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[k+1][l] <= ge[l] ? trial[l] - {1'b0, det_s[k]} : trial[l];
				q_s[k+1][l]   <= {q_s[k][l][QB-2:0], ge[l]};
			end
			numlo_s[k+1] <= numlo_s[k];
			det_s[k+1]   <= det_s[k];
			p0_s[k+1]    <= p0_s[k];
		end
	end

	assign ctl_o = ctl_s[QB];
	assign q_o   = q_s[QB];
	assign p0_o  = p0_s[QB];

endmodule

>>> rtl/tcc_checker.sv
// Port-level checker for the circumcenter unit and its bind to the top level.
module tcc_checker #(
	parameter int COORD_WIDTH  = tcc_pkg::COORD_WIDTH_DEF,
	parameter int CENTER_WIDTH = tcc_pkg::CENTER_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic signed [COORD_WIDTH-1:0]  p0_x,
	input logic                           done,
	input logic signed [CENTER_WIDTH-1:0] center_x,
	input logic signed [CENTER_WIDTH-1:0] center_y,
	input logic signed [CENTER_WIDTH-1:0] center_z,
	input logic                           degenerate,
	input logic                           clipped
);
	import tcc_pkg::*;

	localparam int LAT = tcc_latency(CENTER_WIDTH);
	localparam logic signed [CENTER_WIDTH-1:0] CMAX = {1'b0, {(CENTER_WIDTH-1){1'b1}}};
	localparam logic signed [CENTER_WIDTH-1:0] CMIN = {1'b1, {(CENTER_WIDTH-1){1'b0}}};

	a_transfer_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done) else $error("result missing after transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT)) else $error("result without transfer");

	a_degen_p0: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate && (COORD_WIDTH <= CENTER_WIDTH)
		|-> center_x == $past(p0_x, LAT)) else $error("degenerate center is not vertex zero");

	a_clip_edge: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> center_x == CMAX || center_x == CMIN || center_y == CMAX
		|| center_y == CMIN || center_z == CMAX || center_z == CMIN)
		else $error("clip flag without a saturated coordinate");

endmodule

bind tetrahedron_circumcenter_top tcc_checker #(
	.COORD_WIDTH  (COORD_WIDTH),
	.CENTER_WIDTH (CENTER_WIDTH)
) u_tcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.p0_x       (p0_x),
	.done       (done),
	.center_x   (center_x),
	.center_y   (center_y),
	.center_z   (center_z),
	.degenerate (degenerate),
	.clipped    (clipped)
);

>>> tb/tb.sv
// Self-checking testbench for the pipelined tetrahedron circumcenter unit.
module tb;

	localparam int CW = tcc_pkg::COORD_WIDTH_DEF;
	localparam int OW = tcc_pkg::CENTER_WIDTH_DEF;
	localparam int LAT = tcc_pkg::tcc_latency(OW);
	localparam int N_RANDOM = 1130;
	localparam longint CYCLE_LIMIT = 200000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t v [12];
	} tet_t;
	typedef struct {
		logic signed [OW-1:0] cx, cy, cz;
		logic degen, clip;
	} center_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t pin [12];
	logic done;
	logic signed [OW-1:0] center_x, center_y, center_z;
	logic degenerate, clipped;

	tet_t pending_tets [$];
	center_t expected_centers [$];
	int errors = 0;
	int n_results = 0, n_degen = 0, n_clip = 0;
	bit stim_done = 0;
	bit drained = 0;
	longint cycles = 0;
	tet_t t;

	always #5 clk = ~clk;

	initial begin
		foreach (pin[i]) pin[i] = '0;
	end

	tetrahedron_circumcenter_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p0_x(pin[0]), .p0_y(pin[1]), .p0_z(pin[2]),
		.p1_x(pin[3]), .p1_y(pin[4]), .p1_z(pin[5]),
		.p2_x(pin[6]), .p2_y(pin[7]), .p2_z(pin[8]),
		.p3_x(pin[9]), .p3_y(pin[10]), .p3_z(pin[11]),
		.done(done), .center_x(center_x), .center_y(center_y), .center_z(center_z),
		.degenerate(degenerate), .clipped(clipped)
	);

	// Exact circumcenter: numerators and determinant fit comfortably in 128 bits.
	function automatic center_t circumcenter(tet_t t);
		logic signed [127:0] p [4][3];
		logic signed [127:0] b [3], c [3], d [3], cd [3], db [3], bc [3];
		logic signed [127:0] bb, cc, dd, det, num, q, off, r, hi, lo;
		logic signed [127:0] cap;
		center_t res;
		logic signed [OW-1:0] o [3];
		hi = (128'sd1 <<< (OW-1)) - 1;
		lo = -hi - 1;
		cap = 128'sd1 <<< 62;
		res.clip = 1'b0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++) p[i][j] = t.v[i*3+j];
		for (int j = 0; j < 3; j++) begin
			b[j] = p[1][j] - p[0][j];
			c[j] = p[2][j] - p[0][j];
			d[j] = p[3][j] - p[0][j];
		end
		cd[0] = c[1]*d[2] - c[2]*d[1];
		cd[1] = c[2]*d[0] - c[0]*d[2];
		cd[2] = c[0]*d[1] - c[1]*d[0];
		db[0] = d[1]*b[2] - d[2]*b[1];
		db[1] = d[2]*b[0] - d[0]*b[2];
		db[2] = d[0]*b[1] - d[1]*b[0];
		bc[0] = b[1]*c[2] - b[2]*c[1];
		bc[1] = b[2]*c[0] - b[0]*c[2];
		bc[2] = b[0]*c[1] - b[1]*c[0];
		bb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
		cc = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
		dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		det = 2 * (b[0]*cd[0] + b[1]*cd[1] + b[2]*cd[2]);
		res.degen = (det == 0);
		for (int j = 0; j < 3; j++) begin
			off = 0;
			if (!res.degen) begin
				num = cd[j]*bb + db[j]*cc + bc[j]*dd;
				// Signed division in SystemVerilog truncates toward zero.
				q = num / det;
				if (q > cap) q = cap;
				if (q < -cap) q = -cap;
				off = q;
			end
			r = p[0][j] + off;
			if (r > hi) begin r = hi; res.clip = 1'b1; end
			if (r < lo) begin r = lo; res.clip = 1'b1; end
			o[j] = r[OW-1:0];
		end
		res.cx = o[0]; res.cy = o[1]; res.cz = o[2];
		return res;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 2047) - 1024);
			default: return coord_t'($urandom_range(0, 63) - 32);
		endcase
	endfunction

	function automatic tet_t rand_tet();
		tet_t t;
		int mode;
		coord_t base [3];
		mode = $urandom_range(0, 2);
		for (int j = 0; j < 3; j++) base[j] = coord_t'($urandom);
		for (int i = 0; i < 12; i++)
			t.v[i] = (mode == 0) ? rand_coord(0) : base[i%3] + rand_coord(mode);
		// Occasionally make the vertices coplanar to reach the degenerate path.
		if ($urandom_range(0, 19) == 0)
			for (int j = 0; j < 3; j++) t.v[9+j] = t.v[3+j] + t.v[6+j] - t.v[j];
		return t;
	endfunction

	function automatic tet_t make_tet(int a0, a1, a2, b0, b1, b2, c0, c1, c2, d0, d1, d2);
		tet_t t;
		t.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
			coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2), coord_t'(d0),
			coord_t'(d1), coord_t'(d2)};
		return t;
	endfunction

	task automatic add_tet(input tet_t x);
		pending_tets = {pending_tets, x};
	endtask

	initial begin
		// Directed: axis-aligned corner tetrahedron, all-equal points, extreme corners, thin slivers.
		add_tet(make_tet(0,0,0, 256,0,0, 0,256,0, 0,0,256));
		add_tet(make_tet(0,0,0, 0,0,0, 0,0,0, 0,0,0));
		add_tet(make_tet(-32768,-32768,-32768, 32767,-32768,-32768,
			-32768,32767,-32768, -32768,-32768,32767));
		add_tet(make_tet(32767,32767,32767, -32768,32767,32767,
			32767,-32768,32767, 32767,32767,-32768));
		add_tet(make_tet(-32768,-32768,-32768, 32767,32767,32767,
			32767,-32768,32767, -32768,32767,-32768));
		add_tet(make_tet(0,0,0, 32767,0,0, 0,32767,0, 1,1,1));
		add_tet(make_tet(-32768,0,0, 32767,0,1, 0,32767,0, 0,0,-32768));
		add_tet(make_tet(0,0,0, 1,0,0, 0,1,0, 32767,32767,1));
		add_tet(make_tet(100,200,300, 101,200,300, 100,201,300, 100,200,301));
		add_tet(make_tet(0,0,0, 1,2,3, 2,4,6, 5,1,-7));
		add_tet(make_tet(-1,-1,-1, 0,0,0, 1,1,1, -32768,32767,0));
		add_tet(make_tet(32767,-32768,0, -32768,32767,0, 0,0,32767,
			1,-1,-32768));
		add_tet(make_tet(-5,-5,-5, 5,-5,-5, -5,5,-5, -5,-5,5));
		for (int i = 0; i < N_RANDOM; i++) add_tet(rand_tet());
		stim_done = 1;
	end

	// Driver: random gaps except in a back-to-back window; once pauses until the pipe drains.
	int sent = 0;
	always @(posedge clk) begin
		bit go;
		if (arst_n) begin
			if (start && !busy) sent <= sent + 1;
			go = pending_tets.size() > 0 &&
				((sent > 400 && sent < 600) || $urandom_range(0, 99) >= 29);
			if (sent >= 300 && !drained) begin
				if (expected_centers.size() > 0)
					go = 0;
				else
					drained = 1'b1;
			end
			if (start && busy) go = 1;
			if (go && !(start && busy)) begin
				t = pending_tets.pop_front();
				foreach (pin[i]) pin[i] <= t.v[i];
				expected_centers = {expected_centers, circumcenter(t)};
			end
			start <= go;
		end
	end

	// Monitor: compare every strobed result with the oldest prediction.
	always @(posedge clk) begin
		center_t e;
		if (arst_n && done) begin
			if (expected_centers.size() == 0) begin
				$display("%0t: unexpected result %h %h %h", $realtime, center_x, center_y,
					center_z);
				errors++;
			end else begin
				e = expected_centers.pop_front();
				n_results++;
				if (e.degen) n_degen++;
				if (e.clip) n_clip++;
				if ({center_x, center_y, center_z, degenerate, clipped} !==
					{e.cx, e.cy, e.cz, e.degen, e.clip}) begin
					$display("%0t: expected %0d %0d %0d deg=%b clip=%b, got %0d %0d %0d deg=%b clip=%b",
						$realtime, e.cx, e.cy, e.cz, e.degen, e.clip,
						center_x, center_y, center_z, degenerate, clipped);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && pending_tets.size() == 0 && !start)) @(posedge clk);
		while (expected_centers.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
		$display("Checked %0d circumcenters, %0d degenerate and %0d clipped.",
			n_results, n_degen, n_clip);
		if (errors == 0 && expected_centers.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
